// ===== design/dfmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Digit-framed message checker package
// Shared constants, request and result types, and digit helpers.
// ----------------------------------------------------------------------------
package dfmc_pkg;

	localparam int FIELD_DIGITS    = 4;
	localparam int HEADER_BYTES    = 2 * FIELD_DIGITS;
	localparam int MIN_FRAME       = 3 * FIELD_DIGITS;
	localparam int MAX_FRAME_BYTES = 65535;

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int VAL_W = 14;
	localparam int ODD_W = 17;

	localparam logic [POS_W-1:0] POS_LEAVE    = POS_W'(FIELD_DIGITS);
	localparam logic [POS_W-1:0] POS_HDR      = POS_W'(HEADER_BYTES);
	localparam logic [POS_W-1:0] POS_VALID    = POS_W'(HEADER_BYTES + FIELD_DIGITS);
	localparam logic [POS_W-1:0] POS_LAST_MIN = POS_W'(MIN_FRAME - 1);
	localparam logic [POS_W-1:0] POS_MAX      = POS_W'(MAX_FRAME_BYTES);
	localparam logic [ODD_W-1:0] ODD_MAX      = {ODD_W{1'b1}};

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FORMAT   = 2'd1;
	localparam logic [1:0] STATUS_LENGTH   = 2'd2;
	localparam logic [1:0] STATUS_CHECKSUM = 2'd3;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_frame;
	} rx_item_t;

	typedef struct packed {
		logic [7:0]       payload_byte;
		logic             payload_valid;
		logic             frame_done;
		logic [1:0]       frame_status;
		logic [VAL_W-1:0] mark_value;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
	endfunction

	function automatic logic [3:0] digit_val(input logic [7:0] c);
		logic [7:0] diff;
		diff = c - ASCII_ZERO;
		return is_digit(c) ? diff[3:0] : 4'd0;
	endfunction

endpackage

// ===== design/dfmc_if.sv =====
// ----------------------------------------------------------------------------
// Digit-framed message checker channels
// Valid/ready channels for received bytes and for results.
// ----------------------------------------------------------------------------
interface dfmc_rx_if;
	logic               valid;
	logic               ready;
	dfmc_pkg::rx_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dfmc_res_if;
	logic              valid;
	logic              ready;
	dfmc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/dfmc_frame_state.sv =====
// ----------------------------------------------------------------------------
// Frame state and status logic
// Running frame counters, header decoding, the four-byte delay line and the
// status decision on the last byte of a frame.
// ----------------------------------------------------------------------------
module dfmc_frame_state (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  dfmc_pkg::rx_item_t item,
	output dfmc_pkg::result_t  result
);

	logic [dfmc_pkg::POS_W-1:0] pos_q;
	logic [dfmc_pkg::VAL_W-1:0] size_q;
	logic [dfmc_pkg::VAL_W-1:0] mark_q;
	logic                       hdr_ok_q;
	logic [dfmc_pkg::ODD_W-1:0] odd_q;
	logic [7:0]                 tail_q [dfmc_pkg::FIELD_DIGITS];

	logic [dfmc_pkg::VAL_W-1:0] size_nxt;
	logic [dfmc_pkg::VAL_W-1:0] mark_nxt;
	logic                       hdr_ok_nxt;
	logic [dfmc_pkg::ODD_W-1:0] odd_nxt;
	logic [7:0]                 tail_nxt [dfmc_pkg::FIELD_DIGITS];
	logic [dfmc_pkg::VAL_W-1:0] check_val;
	logic                       check_ok;
	logic [17:0]                hdr_mul;
	logic [3:0]                 d;
	logic [7:0]                 leaving;
	logic                       leaves;
	logic                       pay_valid;
	logic                       in_hdr;
	logic [1:0]                 status;

	always_comb begin
		logic [7:0] c;
		leaving   = tail_q[0];
		leaves    = pos_q >= dfmc_pkg::POS_LEAVE;
		pay_valid = pos_q >= dfmc_pkg::POS_VALID;
		in_hdr    = pos_q < dfmc_pkg::POS_HDR;

		odd_nxt = odd_q;
		if (leaves && leaving[0] && (odd_q != dfmc_pkg::ODD_MAX)) begin
			odd_nxt = odd_q + dfmc_pkg::ODD_W'(1);
		end

		for (int i = 0; i < dfmc_pkg::FIELD_DIGITS - 1; i++) begin
			tail_nxt[i] = tail_q[i + 1];
		end
		tail_nxt[dfmc_pkg::FIELD_DIGITS-1] = item.rx_byte;

		d = dfmc_pkg::digit_val(item.rx_byte);
		hdr_mul = (pos_q < dfmc_pkg::POS_LEAVE) ? 18'(mark_q) : 18'(size_q);
		hdr_mul = hdr_mul * 18'd10 + 18'(d);
		mark_nxt = mark_q;
		size_nxt = size_q;
		hdr_ok_nxt = hdr_ok_q;
		if (in_hdr) begin
			hdr_ok_nxt = hdr_ok_q & dfmc_pkg::is_digit(item.rx_byte);
			if (pos_q < dfmc_pkg::POS_LEAVE) begin
				mark_nxt = hdr_mul[dfmc_pkg::VAL_W-1:0];
			end else begin
				size_nxt = hdr_mul[dfmc_pkg::VAL_W-1:0];
			end
		end

		check_ok  = 1'b1;
		check_val = '0;
		for (int i = 0; i < dfmc_pkg::FIELD_DIGITS; i++) begin
			c = tail_nxt[i];
			check_ok  = check_ok & dfmc_pkg::is_digit(c);
			check_val = dfmc_pkg::VAL_W'(check_val * dfmc_pkg::VAL_W'(10))
				+ dfmc_pkg::VAL_W'(dfmc_pkg::digit_val(c));
		end

		if ((pos_q < dfmc_pkg::POS_LAST_MIN) || !hdr_ok_nxt || !check_ok) begin
			status = dfmc_pkg::STATUS_FORMAT;
		end else if ((pos_q >= dfmc_pkg::POS_MAX)
			|| ((pos_q - dfmc_pkg::POS_LAST_MIN) != dfmc_pkg::POS_W'(size_nxt))) begin
			status = dfmc_pkg::STATUS_LENGTH;
		end else if (dfmc_pkg::ODD_W'(check_val) != odd_nxt) begin
			status = dfmc_pkg::STATUS_CHECKSUM;
		end else begin
			status = dfmc_pkg::STATUS_OK;
		end

		result.payload_byte  = pay_valid ? leaving : 8'd0;
		result.payload_valid = pay_valid;
		result.frame_done    = item.end_of_frame;
		result.frame_status  = item.end_of_frame ? status : dfmc_pkg::STATUS_OK;
		result.mark_value    = (item.end_of_frame && (status != dfmc_pkg::STATUS_FORMAT))
			? mark_nxt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			size_q   <= '0;
			mark_q   <= '0;
			hdr_ok_q <= 1'b1;
			odd_q    <= '0;
			for (int i = 0; i < dfmc_pkg::FIELD_DIGITS; i++) begin
				tail_q[i] <= '0;
			end
		end else if (step) begin
			if (item.end_of_frame) begin
				pos_q    <= '0;
				size_q   <= '0;
				mark_q   <= '0;
				hdr_ok_q <= 1'b1;
				odd_q    <= '0;
				for (int i = 0; i < dfmc_pkg::FIELD_DIGITS; i++) begin
					tail_q[i] <= '0;
				end
			end else begin
				if (pos_q < dfmc_pkg::POS_MAX) begin
					pos_q <= pos_q + dfmc_pkg::POS_W'(1);
				end
				size_q   <= size_nxt;
				mark_q   <= mark_nxt;
				hdr_ok_q <= hdr_ok_nxt;
				odd_q    <= odd_nxt;
				for (int i = 0; i < dfmc_pkg::FIELD_DIGITS; i++) begin
					tail_q[i] <= tail_nxt[i];
				end
			end
		end
	end

endmodule

// ===== design/digit_framed_message_checker.sv =====
// A request is registered in item_s1 and its result in result_s2.
// Throughput: one byte per cycle while the result side is not stalled; the output
// register takes a new result in the cycle that the previous one is taken.
// Reset clears the valid flags of both pipeline stages and all frame state at once.
// ----------------------------------------------------------------------------
// Digit-framed message checker
// Checks ASCII-framed messages and forwards their payload with a status.
// ----------------------------------------------------------------------------
module digit_framed_message_checker (
	input logic        clk,
	input logic        arst_n,
	dfmc_rx_if.sink    rx,
	dfmc_res_if.source res
);

	dfmc_pkg::rx_item_t item_s1;
	logic               valid_s1;
	dfmc_pkg::result_t  result_s2;
	logic               valid_s2;
	dfmc_pkg::result_t  result_c;
	logic               out_free;
	logic               advance;

	assign out_free = !valid_s2 || res.ready;
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	dfmc_frame_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= rx.data;
		end
		if (advance) begin
			result_s2 <= result_c;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = result_s2;

endmodule

// ===== design/dfmc_checker.sv =====
// ----------------------------------------------------------------------------
// Digit-framed message checker assertions
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dfmc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input dfmc_pkg::result_t res_data
);

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("Result request dropped while stalled.");

	a_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("Result changed while stalled.");

	a_idle_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.frame_done |->
		res_data.frame_status == dfmc_pkg::STATUS_OK && res_data.mark_value == '0)
		else $error("Status or mark shown outside the end of a frame.");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.payload_valid |-> res_data.payload_byte == 8'd0)
		else $error("Payload byte set without payload valid.");

	a_format_mark: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.frame_done
		&& res_data.frame_status == dfmc_pkg::STATUS_FORMAT |-> res_data.mark_value == '0)
		else $error("Mark value reported with a format error.");

endmodule

bind digit_framed_message_checker dfmc_checker u_dfmc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

// ===== bench/digit_framed_message_checker_tb.sv =====
// ----------------------------------------------------------------------------
// Digit-framed message checker testbench
// Sends ASCII-framed messages through the checker, with random gaps on the
// request side and random stalls on the result side. A scoreboard predicts
// the payload stream and the end-of-frame status for every request, and it
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module digit_framed_message_checker_tb;

	class framing_scoreboard;
		int unsigned         bytes_seen;
		int unsigned         size_accum;
		int unsigned         mark_accum;
		bit                  header_clean;
		int unsigned         odd_count;
		logic [7:0]          tail[dfmc_pkg::FIELD_DIGITS];
		dfmc_pkg::result_t   due_results[$];
		int unsigned         mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			bytes_seen   = 0;
			size_accum   = 0;
			mark_accum   = 0;
			header_clean = 1'b1;
			odd_count    = 0;
			foreach (tail[i])
				tail[i] = 8'h00;
		endfunction

		function bit numeral(logic [7:0] c);
			return c >= 8'h30 && c <= 8'h39;
		endfunction

		function void take_byte(dfmc_pkg::rx_item_t req);
			dfmc_pkg::result_t r;
			logic [7:0]        leaving;
			int unsigned       d;
			int unsigned       check_val;
			bit                check_clean;
			logic [1:0]        status;

			leaving = tail[0];
			if (bytes_seen >= dfmc_pkg::FIELD_DIGITS && leaving[0]
					&& odd_count < int'(dfmc_pkg::ODD_MAX))
				odd_count++;
			for (int i = 0; i < dfmc_pkg::FIELD_DIGITS - 1; i++)
				tail[i] = tail[i + 1];
			tail[dfmc_pkg::FIELD_DIGITS - 1] = req.rx_byte;

			if (bytes_seen < dfmc_pkg::HEADER_BYTES) begin
				d = numeral(req.rx_byte) ? req.rx_byte - 8'h30 : 0;
				if (!numeral(req.rx_byte))
					header_clean = 1'b0;
				if (bytes_seen < dfmc_pkg::FIELD_DIGITS)
					mark_accum = (mark_accum * 10 + d) & 32'h3FFF;
				else
					size_accum = (size_accum * 10 + d) & 32'h3FFF;
			end

			r = '0;
			if (bytes_seen >= dfmc_pkg::HEADER_BYTES + dfmc_pkg::FIELD_DIGITS) begin
				r.payload_byte  = leaving;
				r.payload_valid = 1'b1;
			end

			if (req.end_of_frame) begin
				check_val   = 0;
				check_clean = 1'b1;
				foreach (tail[i]) begin
					if (!numeral(tail[i]))
						check_clean = 1'b0;
					else
						check_val = check_val * 10 + (tail[i] - 8'h30);
				end
				if (bytes_seen + 1 < dfmc_pkg::MIN_FRAME || !header_clean || !check_clean)
					status = dfmc_pkg::STATUS_FORMAT;
				else if (bytes_seen >= dfmc_pkg::MAX_FRAME_BYTES ||
						bytes_seen + 1 - dfmc_pkg::MIN_FRAME != size_accum)
					status = dfmc_pkg::STATUS_LENGTH;
				else if (check_val != odd_count)
					status = dfmc_pkg::STATUS_CHECKSUM;
				else
					status = dfmc_pkg::STATUS_OK;
				r.frame_done   = 1'b1;
				r.frame_status = status;
				r.mark_value   = (status == dfmc_pkg::STATUS_FORMAT) ? '0
					: dfmc_pkg::VAL_W'(mark_accum);
				restart();
			end else if (bytes_seen < dfmc_pkg::MAX_FRAME_BYTES) begin
				bytes_seen++;
			end
			due_results.push_back(r);
		endfunction

		function void match_result(dfmc_pkg::result_t got);
			dfmc_pkg::result_t exp;

			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result with no request outstanding: byte=%02h valid=%0b done=%0b",
						got.payload_byte, got.payload_valid, got.frame_done);
				return;
			end
			exp = due_results.pop_front();
			if (exp.payload_byte !== got.payload_byte || exp.payload_valid !== got.payload_valid ||
					exp.frame_done !== got.frame_done || exp.frame_status !== got.frame_status ||
					exp.mark_value !== got.mark_value) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"Mismatch: expected byte=%02h valid=%0b done=%0b status=%0d mark=%0d,",
						" got byte=%02h valid=%0b done=%0b status=%0d mark=%0d"},
						exp.payload_byte, exp.payload_valid, exp.frame_done, exp.frame_status,
						exp.mark_value, got.payload_byte, got.payload_valid, got.frame_done,
						got.frame_status, got.mark_value);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   burst;

	dfmc_rx_if  rx_ch();
	dfmc_res_if res_ch();

	framing_scoreboard ledger = new();

	digit_framed_message_checker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("FAIL");
		$finish;
	end

	function automatic void put_decimal(ref logic [7:0] q[$], input int unsigned v);
		q.push_back(dfmc_pkg::ASCII_ZERO + 8'((v / 1000) % 10));
		q.push_back(dfmc_pkg::ASCII_ZERO + 8'((v / 100) % 10));
		q.push_back(dfmc_pkg::ASCII_ZERO + 8'((v / 10) % 10));
		q.push_back(dfmc_pkg::ASCII_ZERO + 8'(v % 10));
	endfunction

	function automatic int unsigned odd_bytes(logic [7:0] q[$]);
		int unsigned n;

		n = 0;
		foreach (q[i])
			n += q[i][0];
		return n;
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] c;

		case ($urandom_range(0, 4))
			0: c = 8'h2F;
			1: c = 8'h3A;
			2: c = 8'h00;
			3: c = 8'hFF;
			default: begin
				do c = 8'($urandom_range(0, 255));
				while (c >= dfmc_pkg::ASCII_ZERO && c <= dfmc_pkg::ASCII_NINE);
			end
		endcase
		return c;
	endfunction

	task automatic send_frame(input logic [7:0] frame[$]);
		int unsigned        gap;
		dfmc_pkg::rx_item_t req;

		for (int i = 0; i < frame.size(); i++) begin
			gap = burst ? 0 : $urandom_range(0, 14);
			if (gap != 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req.rx_byte      = frame[i];
			req.end_of_frame = (i == frame.size() - 1);
			rx_ch.data  <= req;
			rx_ch.valid <= 1'b1;
			do @(posedge clk);
			while (!rx_ch.ready);
			ledger.take_byte(req);
		end
	endtask

	task automatic random_frame(output int unsigned sent);
		logic [7:0]  frame[$];
		int unsigned kind;
		int unsigned mark;
		int unsigned plen;
		int unsigned declared;
		int unsigned check;
		int unsigned n;

		kind = $urandom_range(0, 11);
		case ($urandom_range(0, 7))
			0: mark = 0;
			1: mark = 9999;
			default: mark = $urandom_range(0, 9999);
		endcase
		plen = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
		declared = plen;
		if (kind == 6) begin
			if (plen > 0 && $urandom_range(0, 1))
				declared = plen - 1;
			else
				declared = plen + $urandom_range(1, 3);
		end

		if (kind == 9) begin
			n = $urandom_range(1, dfmc_pkg::MIN_FRAME - 1);
			repeat (n)
				frame.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
					: dfmc_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)));
		end else if (kind == 10) begin
			n = $urandom_range(1, 30);
			repeat (n)
				frame.push_back(8'($urandom_range(0, 255)));
		end else begin
			put_decimal(frame, mark);
			put_decimal(frame, declared);
			repeat (plen)
				frame.push_back(8'($urandom_range(0, 255)));
			check = odd_bytes(frame);
			if (kind == 7)
				check = (check + $urandom_range(1, 9999)) % 10000;
			put_decimal(frame, check);
			if (kind == 8) begin
				if ($urandom_range(0, 2) == 0)
					frame[frame.size() - 1 - $urandom_range(0, dfmc_pkg::FIELD_DIGITS - 1)]
						= non_digit();
				else
					frame[$urandom_range(0, dfmc_pkg::HEADER_BYTES - 1)] = non_digit();
			end
		end
		sent = frame.size();
		send_frame(frame);
	endtask

	initial begin
		logic [7:0]  frame[$];
		int unsigned random_items;
		int unsigned n;

		arst_n      <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.data  <= '0;
		burst = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A frame of one byte, then the shortest valid frame, then one byte too short.
		frame = {8'hFF};
		send_frame(frame);
		frame = {};
		put_decimal(frame, 9999);
		put_decimal(frame, 0);
		put_decimal(frame, odd_bytes(frame));
		send_frame(frame);
		frame = {};
		repeat (dfmc_pkg::MIN_FRAME - 1)
			frame.push_back(dfmc_pkg::ASCII_ZERO);
		send_frame(frame);

		random_items = 0;
		while (random_items < 1450) begin
			burst = ($urandom_range(0, 5) == 0);
			random_frame(n);
			random_items += n;
		end

		burst = 1'b0;
		rx_ch.valid <= 1'b0;

		n = 0;
		while (ledger.due_results.size() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);

		if (ledger.mismatches == 0 && ledger.due_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		int unsigned stall;

		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk);
			while (!res_ch.valid);
			ledger.match_result(res_ch.data);
		end
	end

endmodule
